// ----- rtl/heat_diffusion_grid_defines.svh -----
// Assertion macros shared by the heat diffusion grid RTL.
`ifndef HEAT_DIFFUSION_GRID_DEFINES_SVH
`define HEAT_DIFFUSION_GRID_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define HDG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("heat diffusion grid: assertion failed");
`define HDG_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("heat diffusion grid: forbidden condition");
`else
`define HDG_ASSERT(lbl, prop)
`define HDG_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ----- rtl/hdg_pkg.sv -----
// Shared types and constants of the heat diffusion grid.
`default_nettype none
package hdg_pkg;

  // Opcodes of an input item
  localparam logic OP_DEPOSIT = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // Configuration register indexes
  localparam logic REG_DECAY = 1'b0;
  localparam logic REG_CAP   = 1'b1;

  // Reset values and limits
  localparam logic [15:0] DECAY_RESET = 16'd30;
  localparam logic [15:0] CAP_RESET   = 16'h01FF;
  localparam logic [15:0] SAT_MAX     = 16'hFFFF;
  localparam logic [7:0]  LEVEL_MAX   = 8'hFF;
  localparam int          NB_COUNT    = 8;
  localparam int          DIV_SHIFT   = 3;

  // Command queue depth
  localparam int QDEPTH = 2;

  // Classified command passed from front to back
  typedef struct packed {
    logic       is_tick;
    logic [3:0] col;
    logic [1:0] row;
    logic [7:0] amount;
  } hdg_cmd_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_DEP_RD,
    B_DEP_WR,
    B_DIFF,
    B_REPORT
  } hdg_bstate_t;

endpackage
`default_nettype wire

// ----- rtl/hdg_front.sv -----
// Front end: accepts items, tracks the run flag and classifies work for the back end.
`default_nettype none
module hdg_front #(
  parameter int GRID_COLS = 16,
  parameter int GRID_ROWS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             opcode,
  input  logic [3:0]       cell_col,
  input  logic [1:0]       cell_row,
  input  logic [7:0]       heat_amount,
  input  logic             q_full,
  output logic             push,
  output hdg_pkg::hdg_cmd_t push_cmd
);
  import hdg_pkg::*;

  logic running;
  logic running_next;
  logic accept;
  logic in_grid;
  logic amt_zero;

  assign accept   = start & ~q_full;
  assign in_grid  = ({1'b0, cell_col} < 5'(GRID_COLS)) && ({1'b0, cell_row} < 3'(GRID_ROWS));
  assign amt_zero = (heat_amount == 8'd0);

  // Classification: deposits that change no cell and idle ticks are dropped here; a zero deposit stops a run
  always_comb begin
    running_next = running;
    push         = 1'b0;
    if (accept) begin
      unique case (opcode)
        OP_DEPOSIT: begin
          if (!running) begin
            running_next = 1'b1;
            push         = in_grid & ~amt_zero;
          end else if (amt_zero) begin
            running_next = 1'b0;
          end else begin
            push = in_grid;
          end
        end
        OP_TICK: begin
          push = running;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  assign push_cmd.is_tick = (opcode == OP_TICK);
  assign push_cmd.col     = cell_col;
  assign push_cmd.row     = cell_row;
  assign push_cmd.amount  = heat_amount;

  // Run flag
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else begin
      running <= running_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hdg_queue.sv -----
// Short command queue between front and back end.
`default_nettype none
`include "heat_diffusion_grid_defines.svh"
module hdg_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hdg_pkg::hdg_cmd_t push_cmd,
  input  logic              pop,
  output hdg_pkg::hdg_cmd_t head,
  output logic              not_empty,
  output logic              full
);
  import hdg_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CNTW = $clog2(QDEPTH + 1);

  hdg_cmd_t        entries [QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;

  assign not_empty = (count != '0);
  assign full      = (count == CNTW'(QDEPTH));
  assign head      = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `HDG_ASSERT_NEVER(a_q_overflow, push && full && !pop)
  `HDG_ASSERT_NEVER(a_q_underflow, pop && !not_empty)
  `HDG_ASSERT(a_q_count_range, count <= CNTW'(QDEPTH))

endmodule
`default_nettype wire

// ----- rtl/hdg_back.sv -----
// Back end: cell memory, deposit read-modify-write and the two-pass tick sweep.
`default_nettype none
`include "heat_diffusion_grid_defines.svh"
module hdg_back #(
  parameter int GRID_COLS = 16,
  parameter int GRID_ROWS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  hdg_pkg::hdg_cmd_t cmd,
  input  logic              cmd_valid,
  output logic              cmd_take,
  input  logic [15:0]       decay_step,
  input  logic [15:0]       deposit_cap,
  output logic              strobe,
  output logic [3:0]        out_col,
  output logic [1:0]        out_row,
  output logic [7:0]        level,
  output logic              last
);
  import hdg_pkg::*;

  localparam int N    = GRID_COLS * GRID_ROWS;
  localparam int IW   = $clog2(N);
  localparam int SW   = $clog2(N + GRID_COLS + 4);
  localparam int LINE = 2 * GRID_COLS + 3;
  localparam int CW   = $clog2(GRID_COLS);
  localparam int RW   = $clog2(GRID_ROWS);
  localparam logic [SW-1:0] STEP_LAST = SW'(N + GRID_COLS + 3);
  localparam logic [SW-1:0] FEED_LAST = SW'(N + GRID_COLS);
  localparam logic [SW-1:0] CTR_OFS   = SW'(GRID_COLS + 1);
  localparam logic [SW-1:0] N_TAG     = SW'(N);
  localparam logic [CW-1:0] COL_MAX   = CW'(GRID_COLS - 1);
  localparam logic [RW-1:0] ROW_MAX   = RW'(GRID_ROWS - 1);

  hdg_bstate_t state;
  hdg_bstate_t state_next;
  logic        sweeping;

  logic [SW-1:0] step;
  logic [IW-1:0] dep_idx;
  logic [7:0]    dep_amt;

  // Cell memory and its valid bits
  logic [15:0]  mem [N];
  logic [N-1:0] vld;
  logic [IW-1:0] raddr;
  logic [15:0]  rdata;
  logic         rvld;
  logic         we;
  logic [IW-1:0] waddr;
  logic [15:0]  wdata;
  logic [15:0]  rcell;

  // Window shift line
  logic          feed_v;
  logic [SW-1:0] feed_idx;
  logic [15:0]   feed_val;
  logic [15:0]   sh [LINE];
  logic          tap_v;
  logic [SW-1:0] tap_idx;
  logic [CW-1:0] ctr_c;
  logic [RW-1:0] ctr_r;
  logic          cv;
  logic          ctr_clr;

  // Window arithmetic
  logic [15:0] center;
  logic [15:0] nb   [NB_COUNT];
  logic [15:0] diff [NB_COUNT];
  logic [17:0] psum0;
  logic [17:0] psum1;
  logic [15:0] base;

  // Stage A registers
  logic          va;
  logic          rep_a;
  logic [15:0]   da [NB_COUNT];
  logic [15:0]   base_a;
  logic [17:0]   ps0_a;
  logic [17:0]   ps1_a;
  logic [IW-1:0] idx_a;
  logic [CW-1:0] col_a;
  logic [RW-1:0] row_a;
  logic          last_a;

  // Stage B arithmetic
  logic [18:0] dsum;
  logic [15:0] dsat;
  logic [15:0] heat_new;
  logic [18:0] rsum;
  logic [15:0] ravg;
  logic        diff_we;
  logic        dep_we;

  assign sweeping = (state == B_DIFF) || (state == B_REPORT);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          state_next = cmd.is_tick ? B_DIFF : B_DEP_RD;
        end
      end
      B_DEP_RD: state_next = B_DEP_WR;
      B_DEP_WR: state_next = B_IDLE;
      B_DIFF: begin
        if (step == STEP_LAST) begin
          state_next = B_REPORT;
        end
      end
      B_REPORT: begin
        if (step == STEP_LAST) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    cmd_take = (state == B_IDLE) && cmd_valid;
    raddr    = (state == B_DEP_RD) ? dep_idx : step[IW-1:0];
    ctr_clr  = !sweeping || (step == STEP_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= (sweeping && step != STEP_LAST) ? step + 1'b1 : '0;
    end
  end

  // Latch a deposit command
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      dep_idx <= IW'(int'(cmd.row) * GRID_COLS + int'(cmd.col));
      dep_amt <= cmd.amount;
    end
  end

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rvld <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      rvld <= vld[raddr];
    end
  end

  assign rcell = rvld ? rdata : '0;

  // Deposit write: cells above the cap are left alone
  assign dep_we = (state == B_DEP_WR) && !(rcell > deposit_cap);

  always_comb begin
    we    = dep_we | diff_we;
    waddr = dep_we ? dep_idx : idx_a;
    wdata = dep_we ? (rcell + 16'(dep_amt)) : heat_new;
  end

  // Feed the shift line in row-major order, zeros past the end
  assign feed_val = (feed_idx < N_TAG) ? rcell : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      feed_v <= 1'b0;
      tap_v  <= 1'b0;
    end else begin
      feed_v <= sweeping && (step <= FEED_LAST);
      tap_v  <= feed_v;
    end
  end

  always_ff @(posedge clk) begin
    feed_idx <= step;
    tap_idx  <= feed_idx;
    if (feed_v) begin
      sh[0] <= feed_val;
      for (int i = 1; i < LINE; i++) begin
        sh[i] <= sh[i-1];
      end
    end
  end

  // Centre cell position counters
  assign cv = tap_v && (tap_idx >= CTR_OFS);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr_c <= '0;
      ctr_r <= '0;
    end else if (ctr_clr) begin
      ctr_c <= '0;
      ctr_r <= '0;
    end else if (cv) begin
      if (ctr_c == COL_MAX) begin
        ctr_c <= '0;
        ctr_r <= ctr_r + 1'b1;
      end else begin
        ctr_c <= ctr_c + 1'b1;
      end
    end
  end

  // Neighbours from fixed taps, border masked to zero
  always_comb begin
    int  k;
    logic ok;
    k      = 0;
    center = sh[GRID_COLS+1];
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (!(dr == 0 && dc == 0)) begin
          ok = !((dr == -1 && ctr_r == '0) || (dr == 1 && ctr_r == ROW_MAX) ||
                 (dc == -1 && ctr_c == '0) || (dc == 1 && ctr_c == COL_MAX));
          nb[k]   = ok ? sh[GRID_COLS + 1 - dr * GRID_COLS - dc] : '0;
          diff[k] = (nb[k] > center) ? nb[k] - center : '0;
          k++;
        end
      end
    end
    psum0 = 18'(nb[0]) + 18'(nb[1]) + 18'(nb[2]) + 18'(nb[3]);
    psum1 = 18'(nb[4]) + 18'(nb[5]) + 18'(nb[6]) + 18'(nb[7]);
    base  = (center > decay_step) ? center - decay_step : '0;
  end

  // Stage A
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= cv;
    end
  end

  always_ff @(posedge clk) begin
    rep_a  <= (state == B_REPORT);
    da     <= diff;
    base_a <= base;
    ps0_a  <= psum0;
    ps1_a  <= psum1;
    idx_a  <= IW'(tap_idx - CTR_OFS);
    col_a  <= ctr_c;
    row_a  <= ctr_r;
    last_a <= (ctr_c == COL_MAX) && (ctr_r == ROW_MAX);
  end

  // Stage B: new heat, and the neighbour average that the result registers clamp
  always_comb begin
    dsum = '0;
    for (int i = 0; i < NB_COUNT; i++) begin
      dsum = dsum + 19'(da[i]);
    end
    dsat     = (dsum > 19'(SAT_MAX)) ? SAT_MAX : dsum[15:0];
    heat_new = base_a + (dsat >> DIV_SHIFT);
    rsum     = 19'(ps0_a) + 19'(ps1_a);
    ravg     = 16'(rsum >> DIV_SHIFT);
    diff_we  = va && !rep_a;
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= va && rep_a;
    end
  end

  always_ff @(posedge clk) begin
    out_col <= 4'(col_a);
    out_row <= 2'(row_a);
    level   <= (ravg > 16'(LEVEL_MAX)) ? LEVEL_MAX : ravg[7:0];
    last    <= last_a;
  end

  `HDG_ASSERT(a_we_phase, we |-> (state == B_DIFF || state == B_DEP_WR))
  `HDG_ASSERT(a_strobe_phase, strobe |-> $past(state == B_REPORT))
  `HDG_ASSERT(a_gap_after_last, (strobe && last) |=> !strobe)

endmodule
`default_nettype wire

// ----- rtl/heat_diffusion_grid.sv -----
// Top level of the heat diffusion grid: configuration registers and the three parts.
// A deposit goes through a read state and a write state in the back end; an idle tick or
// a stop costs nothing there. A tick sweeps the cell memory twice, bounded by the single
// memory read port. Results follow one a cycle.
// The receiver cannot stall; busy rises only while the two-entry command queue is full.
// Synchronous reset clears the grid at once through per-cell valid bits and stops the block.
`default_nettype none
module heat_diffusion_grid #(
  parameter int GRID_COLS = 16,
  parameter int GRID_ROWS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [3:0]  cell_col,
  input  logic [1:0]  cell_row,
  input  logic [7:0]  heat_amount,
  output logic        strobe,
  output logic [3:0]  out_col,
  output logic [1:0]  out_row,
  output logic [7:0]  level,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hdg_pkg::*;

  logic [15:0] decay_step;
  logic [15:0] deposit_cap;
  logic        cfg_we;
  logic        q_full;
  logic        q_not_empty;
  logic        q_pop;
  logic        push;
  hdg_cmd_t    push_cmd;
  hdg_cmd_t    head;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_step  <= DECAY_RESET;
      deposit_cap <= CAP_RESET;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_DECAY: decay_step  <= pwdata[15:0];
        REG_CAP:   deposit_cap <= pwdata[15:0];
        default:   decay_step  <= decay_step;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DECAY: prdata = {16'd0, decay_step};
      REG_CAP:   prdata = {16'd0, deposit_cap};
      default:   prdata = '0;
    endcase
  end

  assign busy = q_full;

  hdg_front #(
    .GRID_COLS(GRID_COLS),
    .GRID_ROWS(GRID_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .opcode     (opcode),
    .cell_col   (cell_col),
    .cell_row   (cell_row),
    .heat_amount(heat_amount),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  hdg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head),
    .not_empty(q_not_empty),
    .full     (q_full)
  );

  hdg_back #(
    .GRID_COLS(GRID_COLS),
    .GRID_ROWS(GRID_ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (head),
    .cmd_valid  (q_not_empty),
    .cmd_take   (q_pop),
    .decay_step (decay_step),
    .deposit_cap(deposit_cap),
    .strobe     (strobe),
    .out_col    (out_col),
    .out_row    (out_row),
    .level      (level),
    .last       (last)
  );

endmodule
`default_nettype wire
